// ===== hw/rtl/crc16pf_pkg.sv =====
// Shared types and constants for the CRC-16 packet framer.
package crc16pf_pkg;

    // Largest payload length a start item may request.
    localparam logic [16:0] MAX_PAYLOAD = 17'd1024;
    // Header bytes plus the two CRC bytes.
    localparam logic [11:0] FRAME_OVERHEAD = 12'd14;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_FRAME    = 2'd0,
        STATUS_OVERSIZE = 2'd1,
        STATUS_ORDER    = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYNC_FIRST    = 3'd0;
    localparam logic [2:0] CFG_SYNC_SECOND   = 3'd1;
    localparam logic [2:0] CFG_PROTO_VERSION = 3'd2;
    localparam logic [2:0] CFG_MESSAGE_KIND  = 3'd3;
    localparam logic [2:0] CFG_CRC_POLY      = 3'd4;
    localparam logic [2:0] CFG_CRC_SEED      = 3'd5;
    localparam logic [2:0] CFG_MAX_FRAME     = 3'd6;

    // Byte positions within the emitted header and trailing CRC.
    localparam logic [3:0] IDX_SYNC_FIRST  = 4'd0;
    localparam logic [3:0] IDX_SYNC_SECOND = 4'd1;
    localparam logic [3:0] IDX_VERSION     = 4'd2;
    localparam logic [3:0] IDX_KIND        = 4'd3;
    localparam logic [3:0] IDX_SEQ_LO      = 4'd4;
    localparam logic [3:0] IDX_SEQ_HI      = 4'd5;
    localparam logic [3:0] IDX_TSTAMP_FIRST = 4'd6;
    localparam logic [3:0] IDX_TSTAMP_LAST = 4'd9;
    localparam logic [3:0] IDX_LEN_LO      = 4'd10;
    localparam logic [3:0] IDX_LEN_HI      = 4'd11;
    localparam logic [3:0] IDX_CRC_LO      = 4'd12;
    localparam logic [3:0] IDX_CRC_HI      = 4'd13;

    typedef struct packed {
        op_t         op;
        logic [10:0] frame_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
    } result_t;

    // One byte through an MSB-first CRC-16 with a programmable polynomial.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crc16_packet_framer_unit.sv =====
// Byte-serial packet framer that emits a header, payload bytes and a CRC-16 trailer.
// A data item's result shows in the cycle after acceptance; one data item per cycle while
// the output is free, and the last one adds two CRC bytes. A start item that opens a frame
// arms the sequencer, which loads one header (and, for an empty payload, CRC) byte per cycle
// into the output register while it is free. No item is taken while those bytes are loading.
// Reset clears the sequence counter, the CRC, the frame state and loads register defaults.
module crc16_packet_framer_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  crc16pf_pkg::item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output crc16pf_pkg::result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [7:0]  sync_first_reg, sync_second_reg, version_reg, kind_reg;
    logic [15:0] poly_reg, seed_reg;
    logic [10:0] max_frame_reg;

    logic [15:0] seq_count_reg, seq_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [10:0] bytes_left_reg, bytes_left_next;
    logic        frame_open_reg, frame_open_next;
    logic        seq_active_reg, seq_active_next;
    logic [3:0]  seq_idx_reg, seq_idx_next;
    logic [10:0] len_reg, len_next;

    logic                 out_valid_reg, out_valid_next;
    crc16pf_pkg::result_t out_reg, out_next;

    logic       out_free;
    logic [7:0] seq_byte;
    logic       seq_last;
    logic       oversize;

    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || result_ready;
    assign item_ready   = !seq_active_reg && out_free;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign oversize = ({6'd0, item.frame_length} > crc16pf_pkg::MAX_PAYLOAD) ||
                      (({1'b0, item.frame_length} + crc16pf_pkg::FRAME_OVERHEAD) >
                       {1'b0, max_frame_reg});

    always_comb
    begin
        case (seq_idx_reg)
            crc16pf_pkg::IDX_SYNC_FIRST:  seq_byte = sync_first_reg;
            crc16pf_pkg::IDX_SYNC_SECOND: seq_byte = sync_second_reg;
            crc16pf_pkg::IDX_VERSION:     seq_byte = version_reg;
            crc16pf_pkg::IDX_KIND:        seq_byte = kind_reg;
            crc16pf_pkg::IDX_SEQ_LO:      seq_byte = seq_count_reg[7:0];
            crc16pf_pkg::IDX_SEQ_HI:      seq_byte = seq_count_reg[15:8];
            crc16pf_pkg::IDX_LEN_LO:      seq_byte = len_reg[7:0];
            crc16pf_pkg::IDX_LEN_HI:      seq_byte = {5'd0, len_reg[10:8]};
            crc16pf_pkg::IDX_CRC_LO:      seq_byte = crc_reg[7:0];
            crc16pf_pkg::IDX_CRC_HI:      seq_byte = crc_reg[15:8];
            default:                      seq_byte = 8'd0;
        endcase
    end

    // The header ends the item unless an empty payload sends the CRC straight after it.
    assign seq_last = (seq_idx_reg == crc16pf_pkg::IDX_CRC_HI) ||
                      ((seq_idx_reg == crc16pf_pkg::IDX_LEN_HI) && (len_reg != 11'd0));

    always_comb
    begin
        seq_count_next  = seq_count_reg;
        crc_next        = crc_reg;
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;
        seq_active_next = seq_active_reg;
        seq_idx_next    = seq_idx_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_next        = out_reg;

        if (seq_active_reg && out_free) begin
            out_valid_next = 1'b1;
            out_next       = '{out_byte: seq_byte, status: crc16pf_pkg::STATUS_FRAME,
                               last: seq_last};
            if (seq_idx_reg inside {[crc16pf_pkg::IDX_VERSION:crc16pf_pkg::IDX_LEN_HI]}) begin
                crc_next = crc16pf_pkg::crc_feed(crc_reg, seq_byte, poly_reg);
            end
            if (seq_idx_reg == crc16pf_pkg::IDX_LEN_HI) begin
                seq_count_next = seq_count_reg + 16'd1;
                if (len_reg == 11'd0) begin
                    seq_idx_next = crc16pf_pkg::IDX_CRC_LO;
                end else begin
                    seq_active_next = 1'b0;
                    frame_open_next = 1'b1;
                    bytes_left_next = len_reg;
                end
            end else if (seq_idx_reg == crc16pf_pkg::IDX_CRC_HI) begin
                seq_active_next = 1'b0;
            end else begin
                seq_idx_next = seq_idx_reg + 4'd1;
            end
        end else if (item_valid && item_ready) begin
            if (item.op == crc16pf_pkg::OP_START) begin
                if (frame_open_reg) begin
                    out_valid_next = 1'b1;
                    out_next = '{out_byte: 8'd0, status: crc16pf_pkg::STATUS_ORDER, last: 1'b1};
                end else if (oversize) begin
                    out_valid_next = 1'b1;
                    out_next = '{out_byte: 8'd0, status: crc16pf_pkg::STATUS_OVERSIZE,
                                 last: 1'b1};
                end else begin
                    seq_active_next = 1'b1;
                    seq_idx_next    = crc16pf_pkg::IDX_SYNC_FIRST;
                    len_next        = item.frame_length;
                    crc_next        = seed_reg;
                end
            end else begin
                out_valid_next = 1'b1;
                if (!frame_open_reg) begin
                    out_next = '{out_byte: 8'd0, status: crc16pf_pkg::STATUS_ORDER, last: 1'b1};
                end else begin
                    crc_next = crc16pf_pkg::crc_feed(crc_reg, item.data_byte, poly_reg);
                    bytes_left_next = bytes_left_reg - 11'd1;
                    if (bytes_left_reg == 11'd1) begin
                        // Final payload byte: the two CRC bytes follow.
                        frame_open_next = 1'b0;
                        seq_active_next = 1'b1;
                        seq_idx_next    = crc16pf_pkg::IDX_CRC_LO;
                        out_next = '{out_byte: item.data_byte,
                                     status: crc16pf_pkg::STATUS_FRAME, last: 1'b0};
                    end else begin
                        out_next = '{out_byte: item.data_byte,
                                     status: crc16pf_pkg::STATUS_FRAME, last: 1'b1};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_first_reg  <= 8'hAA;
            sync_second_reg <= 8'h55;
            version_reg     <= 8'h01;
            kind_reg        <= 8'h00;
            poly_reg        <= 16'h1021;
            seed_reg        <= 16'hFFFF;
            max_frame_reg   <= 11'd1038;
        end else if (cfg_valid) begin
            case (cfg_index)
                crc16pf_pkg::CFG_SYNC_FIRST:    sync_first_reg  <= cfg_data[7:0];
                crc16pf_pkg::CFG_SYNC_SECOND:   sync_second_reg <= cfg_data[7:0];
                crc16pf_pkg::CFG_PROTO_VERSION: version_reg     <= cfg_data[7:0];
                crc16pf_pkg::CFG_MESSAGE_KIND:  kind_reg        <= cfg_data[7:0];
                crc16pf_pkg::CFG_CRC_POLY:      poly_reg        <= cfg_data;
                crc16pf_pkg::CFG_CRC_SEED:      seed_reg        <= cfg_data;
                crc16pf_pkg::CFG_MAX_FRAME:     max_frame_reg   <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_count_reg  <= 16'd0;
            crc_reg        <= 16'd0;
            bytes_left_reg <= 11'd0;
            frame_open_reg <= 1'b0;
            seq_active_reg <= 1'b0;
            seq_idx_reg    <= crc16pf_pkg::IDX_SYNC_FIRST;
            out_valid_reg  <= 1'b0;
        end else begin
            seq_count_reg  <= seq_count_next;
            crc_reg        <= crc_next;
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
            seq_active_reg <= seq_active_next;
            seq_idx_reg    <= seq_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        out_reg <= out_next;
    end

endmodule

// ===== tb/crc16_packet_framer_unit_tb.sv =====
// Self-checking testbench for the CRC-16 packet framer: directed table, then random traffic.
module crc16_packet_framer_unit_tb;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        crc16pf_pkg::op_t     op;
        logic [10:0]          len;
        logic [7:0]           data;
        logic                 typed;
        crc16pf_pkg::status_t status;
    } stim_row_t;

    typedef struct packed {
        logic [7:0]  sync0;
        logic [7:0]  sync1;
        logic [7:0]  version;
        logic [7:0]  kind;
        logic [15:0] poly;
        logic [15:0] seed;
        logic [10:0] max_frame;
    } framer_cfg_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    crc16pf_pkg::item_t   item;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    crc16pf_pkg::result_t result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [15:0]          cfg_data;

    // Register copies and framing state as the block should hold them.
    logic [7:0]  sh_sync0, sh_sync1, sh_version, sh_kind;
    logic [15:0] sh_poly, sh_seed;
    logic [10:0] sh_max_frame;
    logic [15:0] seq_num;
    logic [15:0] crc_run;
    logic [10:0] payload_left;
    bit          in_frame;

    crc16pf_pkg::result_t frame_out_due [$];
    crc16pf_pkg::result_t want_r;
    int          items_sent = 0;
    int          mismatches = 0;
    int unsigned quiet_cycles = 0;

    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;

    stim_row_t directed_rows [13] = '{
        // Data with no frame open.
        '{crc16pf_pkg::OP_DATA,  11'd0,    8'h00, 1'b1, crc16pf_pkg::STATUS_ORDER},
        // Empty payload: header then CRC.
        '{crc16pf_pkg::OP_START, 11'd0,    8'hFF, 1'b0, crc16pf_pkg::STATUS_FRAME},
        '{crc16pf_pkg::OP_START, 11'd2047, 8'h00, 1'b1, crc16pf_pkg::STATUS_OVERSIZE},
        '{crc16pf_pkg::OP_START, 11'd1025, 8'h00, 1'b1, crc16pf_pkg::STATUS_OVERSIZE},
        '{crc16pf_pkg::OP_START, 11'd3,    8'h00, 1'b0, crc16pf_pkg::STATUS_FRAME},
        // Start while a frame is open.
        '{crc16pf_pkg::OP_START, 11'd5,    8'h00, 1'b1, crc16pf_pkg::STATUS_ORDER},
        '{crc16pf_pkg::OP_DATA,  11'h7FF,  8'hFF, 1'b0, crc16pf_pkg::STATUS_FRAME},
        '{crc16pf_pkg::OP_DATA,  11'd0,    8'h00, 1'b0, crc16pf_pkg::STATUS_FRAME},
        '{crc16pf_pkg::OP_DATA,  11'd0,    8'hA5, 1'b0, crc16pf_pkg::STATUS_FRAME},
        '{crc16pf_pkg::OP_DATA,  11'd0,    8'h5A, 1'b1, crc16pf_pkg::STATUS_ORDER},
        '{crc16pf_pkg::OP_START, 11'd1,    8'h00, 1'b0, crc16pf_pkg::STATUS_FRAME},
        '{crc16pf_pkg::OP_DATA,  11'h400,  8'h80, 1'b0, crc16pf_pkg::STATUS_FRAME},
        '{crc16pf_pkg::OP_START, 11'd0,    8'h00, 1'b0, crc16pf_pkg::STATUS_FRAME}
    };

    crc16_packet_framer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
        acc = acc ^ {b, 8'h00};
        repeat (8)
        begin
            acc = acc[15] ? ((acc << 1) ^ sh_poly) : (acc << 1);
        end
        return acc;
    endfunction

    // Works out the bytes one accepted item should produce and queues them.
    function automatic void compute_framing(input crc16pf_pkg::item_t it);
        crc16pf_pkg::status_t err;
        logic [7:0]           fb [$];
        err = crc16pf_pkg::STATUS_FRAME;
        if (it.op == crc16pf_pkg::OP_START)
        begin
            if (in_frame)
            begin
                err = crc16pf_pkg::STATUS_ORDER;
            end
            else if (int'(it.frame_length) > int'(crc16pf_pkg::MAX_PAYLOAD) ||
                     int'(it.frame_length) + int'(crc16pf_pkg::FRAME_OVERHEAD) >
                     int'(sh_max_frame))
            begin
                err = crc16pf_pkg::STATUS_OVERSIZE;
            end
            else
            begin
                fb = '{sh_sync0, sh_sync1, sh_version, sh_kind, seq_num[7:0], seq_num[15:8],
                       8'h00, 8'h00, 8'h00, 8'h00, it.frame_length[7:0],
                       {5'b0, it.frame_length[10:8]}};
                crc_run = sh_seed;
                // The sync bytes stay outside the CRC.
                for (int i = 2; i < 12; i++)
                begin
                    crc_run = crc_next(crc_run, fb[i]);
                end
                seq_num = seq_num + 16'd1;
                payload_left = it.frame_length;
                in_frame = (it.frame_length != 11'd0);
            end
        end
        else if (!in_frame)
        begin
            err = crc16pf_pkg::STATUS_ORDER;
        end
        else
        begin
            fb.push_back(it.data_byte);
            crc_run = crc_next(crc_run, it.data_byte);
            payload_left = payload_left - 11'd1;
            in_frame = (payload_left != 11'd0);
        end

        if (err != crc16pf_pkg::STATUS_FRAME)
        begin
            frame_out_due.push_back('{8'h00, err, 1'b1});
        end
        else
        begin
            if (!in_frame)
            begin
                fb.push_back(crc_run[7:0]);
                fb.push_back(crc_run[15:8]);
            end
            foreach (fb[i])
            begin
                frame_out_due.push_back('{fb[i], crc16pf_pkg::STATUS_FRAME,
                                          1'(i == fb.size() - 1)});
            end
        end
    endfunction

    function automatic int frame_room();
        int room;
        if (int'(sh_max_frame) < int'(crc16pf_pkg::FRAME_OVERHEAD))
        begin
            return -1;
        end
        room = int'(sh_max_frame) - int'(crc16pf_pkg::FRAME_OVERHEAD);
        return (room > int'(crc16pf_pkg::MAX_PAYLOAD)) ? int'(crc16pf_pkg::MAX_PAYLOAD) : room;
    endfunction

    // Mostly short payloads; the largest allowed length only when it is small.
    function automatic int pick_length(input int room);
        if (room < 0)
        begin
            return $urandom_range(0, 40);
        end
        if (room <= 40 && $urandom_range(7) == 0)
        begin
            return room;
        end
        if (room > 40 && $urandom_range(7) == 0)
        begin
            return $urandom_range(13, 40);
        end
        return $urandom_range(0, (room < 12) ? room : 12);
    endfunction

    function automatic crc16pf_pkg::item_t start_item(input int len);
        return '{crc16pf_pkg::OP_START, 11'(len), 8'($urandom)};
    endfunction

    function automatic crc16pf_pkg::item_t data_item();
        return '{crc16pf_pkg::OP_DATA, 11'($urandom), 8'($urandom)};
    endfunction

    function automatic framer_cfg_t random_settings(input int lo, input int hi);
        return '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom), 11'($urandom_range(lo, hi))};
    endfunction

    task automatic send_item(input crc16pf_pkg::item_t it, input bit typed = 1'b0,
                             input crc16pf_pkg::status_t typed_status =
                                 crc16pf_pkg::STATUS_FRAME);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        items_sent++;
        if (typed)
        begin
            frame_out_due.push_back('{8'h00, typed_status, 1'b1});
        end
        else
        begin
            compute_framing(it);
        end
    endtask

    task automatic run_traffic(input int n);
        int          stop_at;
        int          room;
        int          cut;
        int unsigned pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            room = frame_room();
            pick = $urandom_range(99);
            if (pick < 78)
            begin
                send_item(start_item(pick_length(room)));
                while (in_frame)
                begin
                    send_item(data_item());
                end
            end
            else if (pick < 86)
            begin
                send_item(data_item());
            end
            else if (pick < 93)
            begin
                if (room < 0)
                begin
                    send_item(start_item($urandom_range(0, 2047)));
                end
                else if ($urandom_range(3) == 0)
                begin
                    send_item(start_item(room + 1));
                end
                else
                begin
                    send_item(start_item($urandom_range(room + 1, 2047)));
                end
            end
            else
            begin
                // A frame cut into by a second start, then completed.
                send_item(start_item(pick_length(room)));
                cut = in_frame ? $urandom_range(0, int'(payload_left) - 1) : 0;
                repeat (cut)
                begin
                    send_item(data_item());
                end
                send_item(start_item(pick_length(room)));
                while (in_frame)
                begin
                    send_item(data_item());
                end
            end
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (frame_out_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            crc16pf_pkg::CFG_SYNC_FIRST:    sh_sync0 = val[7:0];
            crc16pf_pkg::CFG_SYNC_SECOND:   sh_sync1 = val[7:0];
            crc16pf_pkg::CFG_PROTO_VERSION: sh_version = val[7:0];
            crc16pf_pkg::CFG_MESSAGE_KIND:  sh_kind = val[7:0];
            crc16pf_pkg::CFG_CRC_POLY:      sh_poly = val;
            crc16pf_pkg::CFG_CRC_SEED:      sh_seed = val;
            crc16pf_pkg::CFG_MAX_FRAME:     sh_max_frame = val[10:0];
            default:                        ;
        endcase
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    task automatic apply_settings(input framer_cfg_t c);
        settle();
        put_reg(crc16pf_pkg::CFG_SYNC_FIRST, {8'($urandom), c.sync0});
        put_reg(crc16pf_pkg::CFG_SYNC_SECOND, {8'($urandom), c.sync1});
        put_reg(crc16pf_pkg::CFG_PROTO_VERSION, {8'($urandom), c.version});
        put_reg(crc16pf_pkg::CFG_MESSAGE_KIND, {8'($urandom), c.kind});
        put_reg(crc16pf_pkg::CFG_CRC_POLY, c.poly);
        put_reg(crc16pf_pkg::CFG_CRC_SEED, c.seed);
        put_reg(crc16pf_pkg::CFG_MAX_FRAME, {5'($urandom), c.max_frame});
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (frame_out_due.size() == 0)
            begin
                $error("result with nothing expected: out_byte %02h status %0d last %0d",
                       result.out_byte, result.status, result.last);
                mismatches++;
            end
            else
            begin
                want_r = frame_out_due.pop_front();
                if (result.out_byte !== want_r.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", want_r.out_byte, result.out_byte);
                    mismatches++;
                end
                if (result.status !== want_r.status)
                begin
                    $error("status: expected %0d, got %0d", want_r.status, result.status);
                    mismatches++;
                end
                if (result.last !== want_r.last)
                begin
                    $error("last: expected %0d, got %0d", want_r.last, result.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("crc16_packet_framer_unit verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        framer_cfg_t c;
        stim_row_t   row;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= crc16pf_pkg::CFG_SYNC_FIRST;
        cfg_data <= 16'h0000;
        sh_sync0 = 8'hAA;
        sh_sync1 = 8'h55;
        sh_version = 8'h01;
        sh_kind = 8'h00;
        sh_poly = 16'h1021;
        sh_seed = 16'hFFFF;
        sh_max_frame = 11'd1038;
        seq_num = 16'h0000;
        crc_run = 16'h0000;
        payload_left = 11'd0;
        in_frame = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Register values straight out of reset.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item('{row.op, row.len, row.data}, row.typed, row.status);
        end
        // A payload past 255 bytes puts a nonzero high byte into the length field.
        send_item(start_item(259));
        while (in_frame)
        begin
            send_item(data_item());
        end
        run_traffic(30);

        // Only empty payloads fit.
        c = '{8'h00, 8'hFF, 8'hFF, 8'h00, 16'hFFFF, 16'h0000, 11'd14};
        apply_settings(c);
        send_gap_pct = 77;
        run_traffic(40);

        // The output is held off long enough for the block to back up its input.
        c = '{8'hFF, 8'h00, 8'h00, 8'hFF, 16'h0000, 16'hFFFF, 11'd1038};
        apply_settings(c);
        send_gap_pct = 0;
        recv_stall_pct = 77;
        hold_requests++;
        run_traffic(45);

        apply_settings(random_settings(14, 60));
        send_gap_pct = 31;
        recv_stall_pct = 31;
        run_traffic(45);

        // A frame limit below the fixed overhead rejects every start.
        apply_settings(random_settings(13, 13));
        run_traffic(15);

        apply_settings(random_settings(14, 1038));
        send_gap_pct = 0;
        recv_stall_pct = 0;
        run_traffic(30);

        settle();
        // Any stray result after the last expected one still gets caught.
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("crc16_packet_framer_unit verification clean");
        end
        else
        begin
            $display("crc16_packet_framer_unit verification failed");
        end
        $finish;
    end

endmodule
